>>> hw/rtl/settings_command_parser_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the settings command parser core
// Shared property shapes: a same-cycle and a next-cycle implication, both
// clocked on the rising edge and disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef SETTINGS_COMMAND_PARSER_CORE_ASSERT_SVH
`define SETTINGS_COMMAND_PARSER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/scp_pkg.sv
// ---------------------------------------------------------------------------
// Settings command parser package
// Character codes, default sizes and the parser control types.
// ---------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  localparam int CHAR_W         = 8;
  localparam int OUT_VALUE_W    = 32;
  localparam int NUM_KEY_OUT    = 3;
  localparam int KEY_LEN_DEF    = 3;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'd0;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [CHAR_W-1:0] CH_BANG   = 8'd33;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'd34;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'd35;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'd36;
  localparam logic [CHAR_W-1:0] CH_DASH   = 8'd45;
  localparam logic [CHAR_W-1:0] CH_0      = 8'd48;
  localparam logic [CHAR_W-1:0] CH_9      = 8'd57;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UF     = 8'd70;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'd102;
  localparam logic [CHAR_W-1:0] CH_X      = 8'd120;

  // Offsets that turn a digit character into its value.
  localparam logic [CHAR_W-1:0] DEC_OFS   = 8'd48;
  localparam logic [CHAR_W-1:0] HEX_UC_OFS = 8'd55;
  localparam logic [CHAR_W-1:0] HEX_LC_OFS = 8'd87;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_TYPE,
    PH_VALUE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEX,
    KIND_DEC,
    KIND_DEL,
    KIND_STR,
    KIND_IGN
  } kind_t;

  typedef struct packed {
    phase_t phase;
    kind_t  kind;
    logic   del;
    logic   err;
  } ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/scp_step.sv
// ---------------------------------------------------------------------------
// Parser step logic
// Next-state and result logic for one command character.
// ---------------------------------------------------------------------------
`default_nettype none

module scp_step #(
  parameter int KEY_LEN    = scp_pkg::KEY_LEN_DEF,
  parameter int VALUE_BITS = scp_pkg::VALUE_BITS_DEF,
  parameter int KCW        = $clog2(KEY_LEN + 1)
) (
  input  wire scp_pkg::ctrl_t             ctrl,
  input  wire logic [KCW-1:0]             key_count,
  input  wire logic [VALUE_BITS-1:0]      acc,
  input  wire logic [scp_pkg::CHAR_W-1:0] c,
  output scp_pkg::ctrl_t                  ctrl_next,
  output logic [KCW-1:0]                  key_count_next,
  output logic [VALUE_BITS-1:0]           acc_next,
  output logic                            key_we,
  output logic                            emit,
  output logic                            res_del,
  output logic                            res_err
);
  import scp_pkg::*;

  logic        do_type;
  logic        bad;
  logic [3:0]  digit;
  logic        is_dec;
  logic        is_uc;
  logic        is_lc;
  logic [KCW-1:0] count_inc;
  kind_t       kind_sel;

  assign count_inc = key_count + KCW'(1);
  assign bad = !((c == CH_DOLLAR) || (c == CH_HASH) || (c == CH_BANG) || (c == CH_QUOTE));
  assign is_dec = (c >= CH_0) && (c <= CH_9);
  assign is_uc  = (c >= CH_UA) && (c <= CH_UF);
  assign is_lc  = (c >= CH_LA) && (c <= CH_LF);

  always_comb begin
    if (is_lc) begin
      digit = 4'(c - HEX_LC_OFS);
    end else if (is_uc) begin
      digit = 4'(c - HEX_UC_OFS);
    end else begin
      digit = 4'(c - DEC_OFS);
    end
  end

  always_comb begin
    case (c)
      CH_DOLLAR: kind_sel = KIND_HEX;
      CH_HASH:   kind_sel = KIND_DEC;
      CH_BANG:   kind_sel = KIND_DEL;
      CH_QUOTE:  kind_sel = KIND_STR;
      default:   kind_sel = KIND_IGN;
    endcase
  end

  always_comb begin
    ctrl_next      = ctrl;
    key_count_next = key_count;
    acc_next       = acc;
    key_we         = 1'b0;
    emit           = 1'b0;
    do_type        = 1'b0;

    unique case (ctrl.phase)
      PH_KEY: begin
        if (c >= CH_DASH) begin
          key_we         = 1'b1;
          key_count_next = count_inc;
          if (count_inc == KCW'(KEY_LEN)) begin
            ctrl_next.phase = PH_TYPE;
          end
        end else begin
          do_type = 1'b1;
        end
      end
      PH_TYPE: begin
        do_type = 1'b1;
      end
      PH_VALUE: begin
        if (c == CH_NUL) begin
          emit = 1'b1;
        end else begin
          case (ctrl.kind)
            KIND_HEX: begin
              if (is_dec || is_uc || is_lc) begin
                acc_next = (acc << 4) + VALUE_BITS'(digit);
              end
            end
            KIND_DEC: begin
              if (is_dec) begin
                acc_next = (acc << 3) + (acc << 1) + VALUE_BITS'(digit);
              end
            end
            KIND_DEL: begin
              if (c == CH_X) begin
                ctrl_next.del  = 1'b1;
                ctrl_next.kind = KIND_IGN;
              end
            end
            KIND_STR: begin
              if (c == CH_QUOTE) begin
                ctrl_next.kind = KIND_IGN;
              end else if (c >= CH_SPACE) begin
                acc_next = (acc << 8) + VALUE_BITS'(c);
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (do_type) begin
      if (c == CH_NUL) begin
        emit = 1'b1;
      end else begin
        ctrl_next.phase = PH_VALUE;
        ctrl_next.kind  = kind_sel;
        ctrl_next.err   = bad;
      end
    end

    // A finished command leaves the parser in its reset state.
    if (emit) begin
      ctrl_next.phase = PH_KEY;
      ctrl_next.kind  = KIND_IGN;
      ctrl_next.del   = 1'b0;
      ctrl_next.err   = 1'b0;
      key_count_next  = '0;
      acc_next        = '0;
    end
  end

  assign res_del = do_type ? 1'b0 : ctrl.del;
  assign res_err = do_type ? bad : ctrl.err;

endmodule

`default_nettype wire

>>> hw/rtl/scp_out_reg.sv
// ---------------------------------------------------------------------------
// Result register
// Holds one finished command until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "settings_command_parser_core_assert.svh"

module scp_out_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [scp_pkg::CHAR_W-1:0]    key0_d,
  input  wire logic [scp_pkg::CHAR_W-1:0]    key1_d,
  input  wire logic [scp_pkg::CHAR_W-1:0]    key2_d,
  input  wire logic [scp_pkg::OUT_VALUE_W-1:0] value_d,
  input  wire logic                          del_d,
  input  wire logic                          err_d,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic [scp_pkg::CHAR_W-1:0]         key_first,
  output logic [scp_pkg::CHAR_W-1:0]         key_second,
  output logic [scp_pkg::CHAR_W-1:0]         key_third,
  output logic signed [scp_pkg::OUT_VALUE_W-1:0] value,
  output logic                               is_delete,
  output logic                               bad_type
);
  import scp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_first  <= key0_d;
      key_second <= key1_d;
      key_third  <= key2_d;
      value      <= signed'(value_d);
      is_delete  <= del_d;
      bad_type   <= err_d;
    end
  end

  `SCP_ASSERT_IMP(a_no_overwrite, clk, rst, load && out_valid, !out_stall, "result overwritten while stalled")
  `SCP_ASSERT_NXT(a_load_valid, clk, rst, load, out_valid, "loaded result not presented")
  `SCP_ASSERT_NXT(a_no_repeat, clk, rst, out_valid && !out_stall && !load, !out_valid, "result repeated")

endmodule

`default_nettype wire

>>> hw/rtl/settings_command_parser_core.sv
// ---------------------------------------------------------------------------
// Settings command parser core
// Parses a key, a type character and a value from a byte stream and
// presents one result per command terminated by a zero byte.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   input    sink       in_valid / in_stall    char_in
//   output   source     out_valid / out_stall  key_first, key_second, key_third,
//                                              value, is_delete, bad_type
//
// Each character is one transfer: the parser state is updated by one pass
// of the step logic and a finished command lands in the result register
// at the same edge, so a zero byte's result appears in the cycle after
// its transfer.
// Reset is synchronous and returns the parser to the key phase with an empty
// result register.
// The input stalls only when a character would finish a command while the
// result register still holds a result that the output side is stalling.
// ---------------------------------------------------------------------------
`default_nettype none
`include "settings_command_parser_core_assert.svh"

module settings_command_parser_core #(
  parameter int KEY_LEN    = scp_pkg::KEY_LEN_DEF,
  parameter int VALUE_BITS = scp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [scp_pkg::CHAR_W-1:0]        char_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [scp_pkg::CHAR_W-1:0]             key_first,
  output logic [scp_pkg::CHAR_W-1:0]             key_second,
  output logic [scp_pkg::CHAR_W-1:0]             key_third,
  output logic signed [scp_pkg::OUT_VALUE_W-1:0] value,
  output logic                                   is_delete,
  output logic                                   bad_type
);
  import scp_pkg::*;

  localparam int KCW       = $clog2(KEY_LEN + 1);
  // Only the characters that reach an output are stored.
  localparam int KEY_STORE = (KEY_LEN < NUM_KEY_OUT) ? KEY_LEN : NUM_KEY_OUT;

  ctrl_t                  ctrl;
  ctrl_t                  ctrl_next;
  logic [KCW-1:0]         key_count;
  logic [KCW-1:0]         key_count_next;
  logic [VALUE_BITS-1:0]  acc;
  logic [VALUE_BITS-1:0]  acc_next;
  logic [CHAR_W-1:0]      key_chars [KEY_STORE];
  logic [CHAR_W-1:0]      key_out [NUM_KEY_OUT];
  logic                   key_we;
  logic                   emit;
  logic                   res_del;
  logic                   res_err;
  logic                   in_fire;
  logic                   load;
  logic                   parser_clear;

  scp_step #(
    .KEY_LEN    (KEY_LEN),
    .VALUE_BITS (VALUE_BITS),
    .KCW        (KCW)
  ) u_step (
    .ctrl           (ctrl),
    .key_count      (key_count),
    .acc            (acc),
    .c              (char_in),
    .ctrl_next      (ctrl_next),
    .key_count_next (key_count_next),
    .acc_next       (acc_next),
    .key_we         (key_we),
    .emit           (emit),
    .res_del        (res_del),
    .res_err        (res_err)
  );

  // A terminating character needs room in the result register; everything
  // else is always taken.
  assign in_stall = out_valid && out_stall && emit;
  assign in_fire  = in_valid && !in_stall;
  assign load     = in_fire && emit;

  // The parser is back at the start of a command.
  assign parser_clear = (ctrl.phase == PH_KEY) && (key_count == '0) && (acc == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase <= PH_KEY;
      ctrl.kind  <= KIND_IGN;
      ctrl.del   <= 1'b0;
      ctrl.err   <= 1'b0;
      key_count  <= '0;
      acc        <= '0;
    end else if (in_fire) begin
      ctrl      <= ctrl_next;
      key_count <= key_count_next;
      acc       <= acc_next;
    end
  end

  // Key characters reset to the dash and are cleared again when a command
  // has been handed to the result register.
  for (genvar j = 0; j < KEY_STORE; j++) begin : g_key
    always_ff @(posedge clk) begin
      if (rst || load) begin
        key_chars[j] <= CH_DASH;
      end else if (in_fire && key_we && (key_count == KCW'(j))) begin
        key_chars[j] <= char_in;
      end
    end
  end

  // Output places beyond a short key always show the dash.
  for (genvar j = 0; j < NUM_KEY_OUT; j++) begin : g_key_out
    if (j < KEY_STORE) begin : g_stored
      assign key_out[j] = key_chars[j];
    end else begin : g_dash
      assign key_out[j] = CH_DASH;
    end
  end

  scp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .key0_d     (key_out[0]),
    .key1_d     (key_out[1]),
    .key2_d     (key_out[2]),
    .value_d    (OUT_VALUE_W'(acc)),
    .del_d      (res_del),
    .err_d      (res_err),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .key_first  (key_first),
    .key_second (key_second),
    .key_third  (key_third),
    .value      (value),
    .is_delete  (is_delete),
    .bad_type   (bad_type)
  );

  `SCP_ASSERT_NXT(a_emit_clears, clk, rst, load, parser_clear, "parser not cleared")
  `SCP_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, key_count <= KCW'(KEY_LEN), "key count too large")
  `SCP_ASSERT_IMP(a_stall_full, clk, rst, in_stall, out_valid, "stall with empty result")

endmodule

`default_nettype wire
